>>> hw/rtl/fnwc_pkg.sv
// ----------------------------------------------------------------------------
// fnwc_pkg: shared types and constants for the frame number wall clock
// codes, field structs and the queue word between front and back
// ----------------------------------------------------------------------------
package fnwc_pkg;

	localparam int unsigned FRAMES_PER_SECOND = 100;
	localparam int unsigned FRAME_MASK        = 1023;
	localparam int unsigned ENABLE_BIT        = 0;
	localparam int unsigned CLOCK_SCALE       = 100;
	localparam int unsigned QDEPTH            = 2;
	localparam int unsigned QAW               = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		FN_TICK = 3'd0, FN_WR = 3'd1, FN_RD = 3'd2, FN_SETF = 3'd3,
		FN_GETF = 3'd4, FN_SETR = 3'd5, FN_GETR = 3'd6, FN_BAD = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		RG_CTRL = 3'd0, RG_PULSE = 3'd1, RG_SNAP = 3'd2, RG_CLOCK = 3'd3,
		RG_BT0 = 3'd4, RG_BT1 = 3'd5, RG_BAD6 = 3'd6, RG_BAD7 = 3'd7
	} reg_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INVAL = 2'd1;
	localparam logic [1:0] ST_IO    = 2'd2;
	localparam logic [1:0] ST_NOREF = 2'd3;

	localparam logic CFG_PERIOD = 1'b0;
	localparam logic CFG_RATE   = 1'b1;

	typedef struct packed {
		logic [2:0]  func;
		logic [2:0]  reg_index;
		logic [31:0] write_data;
		logic [15:0] frame_value;
	} in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  status;
	} out_t;

	// classified command handed from front to back
	typedef struct packed {
		func_t       func;
		reg_t        idx;
		logic [31:0] data;
		logic [15:0] frame;
		logic        frame_ok;
	} cmd_t;

endpackage

>>> hw/rtl/fnwc_front.sv
// ----------------------------------------------------------------------------
// fnwc_front: input stage and command queue
// classifies each transfer and buffers it for the back part
// ----------------------------------------------------------------------------
module fnwc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  fnwc_pkg::in_t   din,
	output logic            cmd_valid,
	input  logic            cmd_take,
	output fnwc_pkg::cmd_t  cmd
);

	fnwc_pkg::cmd_t                mem_q [fnwc_pkg::QDEPTH];
	logic [fnwc_pkg::QAW-1:0]      wp_q, rp_q;
	logic [fnwc_pkg::QAW:0]        cnt_q;
	fnwc_pkg::cmd_t                c;
	logic                          wr, rd;

	always_comb begin
		c.func     = fnwc_pkg::func_t'(din.func);
		c.idx      = fnwc_pkg::reg_t'(din.reg_index);
		c.data     = din.write_data;
		c.frame    = din.frame_value;
		c.frame_ok = ({16'd0, din.frame_value} <= 32'(fnwc_pkg::FRAME_MASK));
	end

	assign full      = (cnt_q == (fnwc_pkg::QAW+1)'(fnwc_pkg::QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = mem_q[rp_q];
	assign wr        = push && !full;
	assign rd        = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (fnwc_pkg::QAW+1)'(wr) - (fnwc_pkg::QAW+1)'(rd);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (fnwc_pkg::QAW+1)'(fnwc_pkg::QDEPTH))
		else $error("queue count overflow");
	a_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not grow");
	a_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(rd && !wr) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count did not shrink");

endmodule

>>> hw/rtl/fnwc_div.sv
// ----------------------------------------------------------------------------
// fnwc_div: radix-2 restoring divider, 39-bit dividend by 30-bit divisor
// one quotient bit per cycle
// ----------------------------------------------------------------------------
module fnwc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [38:0] dividend,
	input  logic [29:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quotient
);

	logic [38:0] q_q;
	logic [30:0] r_q;
	logic [29:0] d_q;
	logic [5:0]  n_q;
	logic [30:0] sh;
	logic [31:0] diff;

	assign sh       = {r_q[29:0], q_q[38]};
	assign diff     = {1'b0, sh} - {2'b0, d_q};
	assign quotient = q_q[31:0];

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy) begin
			if (!diff[31]) begin
				r_q <= diff[30:0];
				q_q <= {q_q[37:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[37:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
			n_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy <= 1'b1;
				n_q  <= 6'd38;
			end else if (busy) begin
				n_q <= n_q - 1'b1;
				if (n_q == '0) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/fnwc_back.sv
// ----------------------------------------------------------------------------
// fnwc_back: executes commands against the counter and register state
// holds one result in an output register
// ----------------------------------------------------------------------------
module fnwc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_take,
	input  fnwc_pkg::cmd_t  cmd,
	input  logic            cfg_we,
	input  logic            cfg_idx,
	input  logic [29:0]     cfg_data,
	output logic            empty,
	input  logic            pop,
	output fnwc_pkg::out_t  dout
);

	typedef enum logic [2:0] {S_IDLE, S_LIM, S_MUL, S_DIV, S_SUM} state_t;

	state_t       st_q;
	logic [7:0]   period_q;
	logic [29:0]  rate_q;
	logic         en_q, refv_q;
	logic [31:0]  ctrl_q, pulse_q, clk_q, snap_q, bt0_q, bt1_q;
	logic [15:0]  ref_q;
	logic [37:0]  lim_q;
	logic [38:0]  scaled_q;
	logic [31:0]  base_q;
	logic         rvalid_q;
	fnwc_pkg::out_t res_q;
	logic         dstart, dbusy, ddone;
	logic [31:0]  quo;
	logic         slot, go;
	logic [32:0]  nxt;
	logic [31:0]  emask;

	assign emask    = 32'd1 << fnwc_pkg::ENABLE_BIT;
	assign slot     = !rvalid_q || pop;
	assign go       = (st_q == S_IDLE) && cmd_valid && slot;
	assign cmd_take = go && !(cmd.func == fnwc_pkg::FN_TICK && en_q) &&
		!(cmd.func == fnwc_pkg::FN_GETF && en_q && refv_q) ||
		(st_q == S_LIM) || (st_q == S_SUM);
	assign empty    = !rvalid_q;
	assign dout     = res_q;
	assign nxt      = {1'b0, clk_q} + 33'd1;
	assign dstart   = (st_q == S_MUL) && (rate_q != '0);

	fnwc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.dividend(scaled_q), .divisor(rate_q),
		.busy(dbusy), .done(ddone), .quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			period_q <= 8'd1;
			rate_q   <= 30'd19200000;
			en_q     <= 1'b0;
			refv_q   <= 1'b0;
			ctrl_q   <= '0;
			pulse_q  <= '0;
			clk_q    <= '0;
			snap_q   <= '0;
			bt0_q    <= '0;
			bt1_q    <= '0;
			ref_q    <= '0;
			rvalid_q <= 1'b0;
			lim_q    <= '0;
			scaled_q <= '0;
			base_q   <= '0;
			res_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == fnwc_pkg::CFG_PERIOD) period_q <= cfg_data[7:0];
				else rate_q <= cfg_data;
			end
			if (pop && rvalid_q) rvalid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (go) begin
						res_q <= '{read_data: '0, status: fnwc_pkg::ST_OK};
						rvalid_q <= 1'b1;
						case (cmd.func)
							fnwc_pkg::FN_TICK: begin
								if (en_q) begin
									rvalid_q <= 1'b0;
									lim_q <= 38'(period_q * rate_q);
									st_q  <= S_LIM;
								end
							end
							fnwc_pkg::FN_WR: begin
								case (cmd.idx)
									fnwc_pkg::RG_CTRL: begin
										if ((cmd.data & emask) != '0) begin
											if (!en_q) begin
												pulse_q <= '0;
												clk_q   <= '0;
												snap_q  <= '0;
												en_q    <= 1'b1;
											end
										end else en_q <= 1'b0;
										ctrl_q <= cmd.data;
									end
									fnwc_pkg::RG_PULSE: pulse_q <= cmd.data;
									fnwc_pkg::RG_SNAP: res_q.status <= fnwc_pkg::ST_IO;
									fnwc_pkg::RG_CLOCK: begin
										clk_q  <= cmd.data;
										snap_q <= cmd.data;
									end
									fnwc_pkg::RG_BT0: bt0_q <= cmd.data;
									fnwc_pkg::RG_BT1: bt1_q <= cmd.data;
									default: res_q.status <= fnwc_pkg::ST_INVAL;
								endcase
							end
							fnwc_pkg::FN_RD: begin
								case (cmd.idx)
									fnwc_pkg::RG_CTRL:  res_q.read_data <= ctrl_q;
									fnwc_pkg::RG_PULSE: res_q.read_data <= pulse_q;
									fnwc_pkg::RG_SNAP:  res_q.read_data <= snap_q;
									fnwc_pkg::RG_CLOCK: res_q.read_data <= clk_q;
									fnwc_pkg::RG_BT0:   res_q.read_data <= bt0_q;
									fnwc_pkg::RG_BT1:   res_q.read_data <= bt1_q;
									default: res_q.status <= fnwc_pkg::ST_INVAL;
								endcase
							end
							fnwc_pkg::FN_SETF: begin
								if (!cmd.frame_ok) res_q.status <= fnwc_pkg::ST_INVAL;
								else begin
									ref_q   <= cmd.frame;
									refv_q  <= 1'b1;
									pulse_q <= '0;
									clk_q   <= '0;
									snap_q  <= '0;
									en_q    <= 1'b1;
									ctrl_q  <= ctrl_q | emask;
								end
							end
							fnwc_pkg::FN_GETF: begin
								if (!en_q || !refv_q) res_q.status <= fnwc_pkg::ST_IO;
								else begin
									rvalid_q <= 1'b0;
									base_q   <= 32'(fnwc_pkg::FRAMES_PER_SECOND) * pulse_q;
									scaled_q <= 39'(clk_q * 7'(fnwc_pkg::CLOCK_SCALE));
									st_q     <= S_MUL;
								end
							end
							fnwc_pkg::FN_SETR: begin
								if (!cmd.frame_ok) res_q.status <= fnwc_pkg::ST_INVAL;
								else begin
									ref_q  <= cmd.frame;
									refv_q <= 1'b1;
								end
							end
							fnwc_pkg::FN_GETR: begin
								if (!refv_q) res_q.status <= fnwc_pkg::ST_NOREF;
								else res_q.read_data <= {16'd0, ref_q};
							end
							default: res_q.status <= fnwc_pkg::ST_INVAL;
						endcase
					end
				end
				S_LIM: begin
					if ({5'd0, nxt} >= lim_q) begin
						clk_q   <= '0;
						snap_q  <= '0;
						pulse_q <= pulse_q + 32'd1;
					end else begin
						clk_q  <= nxt[31:0];
						snap_q <= nxt[31:0];
					end
					rvalid_q <= 1'b1;
					st_q     <= S_IDLE;
				end
				S_MUL: begin
					base_q <= base_q * {24'd0, period_q};
					if (rate_q == '0) st_q <= S_SUM;
					else st_q <= S_DIV;
				end
				S_DIV: begin
					if (ddone) st_q <= S_SUM;
				end
				S_SUM: begin
					res_q.read_data <= (base_q + ((rate_q == '0) ? 32'd0 : quo) +
						{16'd0, ref_q}) & 32'(fnwc_pkg::FRAME_MASK);
					res_q.status <= fnwc_pkg::ST_OK;
					rvalid_q <= 1'b1;
					st_q     <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dbusy |-> st_q == S_DIV)
		else $error("divider running outside divide state");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rvalid_q && !pop) |=> rvalid_q && $stable(res_q))
		else $error("pending result lost");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !go)
		else $error("command started while busy");

endmodule

>>> hw/rtl/frame_number_wall_clock_core.sv
// ----------------------------------------------------------------------------
// frame_number_wall_clock_core: wall-clock counter with register block
// front queue takes commands, back part runs counts, registers and frame math
// ----------------------------------------------------------------------------
// channel  | handshake    | payload
// input    | push / full  | din  (func, reg_index, write_data, frame_value)
// result   | pop / empty  | dout (read_data, status)
// config   | cfg_we       | cfg_index, cfg_data (0 period, 1 rate)
//
// most commands finish in the back part's idle state; an enabled tick goes
// through the limit product, then the compare, and a get frame through the
// multiplies, then the serial divider, one quotient bit per cycle over 39 bits
// the two-entry queue keeps taking transfers while the back part is busy
// a result waits in the output register until popped; the back part stalls
// asynchronous active-low reset restores counters and register block defaults
// ----------------------------------------------------------------------------
module frame_number_wall_clock_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  fnwc_pkg::in_t   din,
	output logic            empty,
	input  logic            pop,
	output fnwc_pkg::out_t  dout,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [29:0]     cfg_data
);

	// queue word between front and back
	fnwc_pkg::cmd_t cmd;
	logic           cmd_valid, cmd_take;

	fnwc_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .din(din),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	fnwc_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.empty(empty), .pop(pop), .dout(dout)
	);

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for frame_number_wall_clock_core
// a queue-fed driver pushes commands, a shadow model of the counters and
// registers predicts each result, and a monitor compares every popped result
// ----------------------------------------------------------------------------
module tb;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           push = 1'b0;
	logic           full;
	fnwc_pkg::in_t  din = '0;
	logic           empty;
	logic           pop = 1'b0;
	fnwc_pkg::out_t dout;
	logic           cfg_we = 1'b0;
	logic           cfg_index = 1'b0;
	logic [29:0]    cfg_data = '0;

	frame_number_wall_clock_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .din(din),
		.empty(empty), .pop(pop), .dout(dout),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// shadow copy of the block state
	logic [7:0]  sh_period;
	logic [29:0] sh_rate;
	logic        sh_en, sh_refv;
	logic [31:0] sh_ctrl, sh_pulse, sh_clock, sh_snap;
	logic [31:0] sh_bt [2];
	logic [15:0] sh_ref;

	fnwc_pkg::in_t  cmd_q [$];      // commands waiting for the driver
	fnwc_pkg::out_t result_q [$];   // predicted results, oldest first
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	bit   hold_push = 1'b0;
	bit   failed = 1'b0;
	int   sent = 0;

	function automatic void shadow_reset();
		sh_period = 8'd1;
		sh_rate = 30'd19200000;
		sh_en = 1'b0;
		sh_refv = 1'b0;
		sh_ctrl = '0;
		sh_pulse = '0;
		sh_clock = '0;
		sh_snap = '0;
		sh_bt[0] = '0;
		sh_bt[1] = '0;
		sh_ref = '0;
	endfunction

	function automatic void write_ctrl(logic [31:0] v);
		if (v[fnwc_pkg::ENABLE_BIT]) begin
			if (!sh_en) begin
				sh_pulse = '0;
				sh_clock = '0;
				sh_snap = '0;
				sh_en = 1'b1;
			end
		end else begin
			sh_en = 1'b0;
		end
		sh_ctrl = v;
	endfunction

	// apply one command to the shadow state and return its result
	function automatic fnwc_pkg::out_t predict_command(fnwc_pkg::in_t c);
		fnwc_pkg::out_t r;
		logic [63:0] lim, nxt, prod;
		logic [31:0] frm;
		r = '0;
		r.status = fnwc_pkg::ST_OK;
		case (fnwc_pkg::func_t'(c.func))
			fnwc_pkg::FN_TICK: begin
				if (sh_en) begin
					lim = 64'(sh_period) * 64'(sh_rate);
					nxt = 64'(sh_clock) + 64'd1;
					if (nxt >= lim) begin
						sh_clock = '0;
						sh_pulse = sh_pulse + 32'd1;
					end else begin
						sh_clock = nxt[31:0];
					end
					sh_snap = sh_clock;
				end
			end
			fnwc_pkg::FN_WR: begin
				case (fnwc_pkg::reg_t'(c.reg_index))
					fnwc_pkg::RG_CTRL:  write_ctrl(c.write_data);
					fnwc_pkg::RG_PULSE: sh_pulse = c.write_data;
					fnwc_pkg::RG_SNAP:  r.status = fnwc_pkg::ST_IO;
					fnwc_pkg::RG_CLOCK: begin
						sh_clock = c.write_data;
						sh_snap = c.write_data;
					end
					fnwc_pkg::RG_BT0:   sh_bt[0] = c.write_data;
					fnwc_pkg::RG_BT1:   sh_bt[1] = c.write_data;
					default:            r.status = fnwc_pkg::ST_INVAL;
				endcase
			end
			fnwc_pkg::FN_RD: begin
				case (fnwc_pkg::reg_t'(c.reg_index))
					fnwc_pkg::RG_CTRL:  r.read_data = sh_ctrl;
					fnwc_pkg::RG_PULSE: r.read_data = sh_pulse;
					fnwc_pkg::RG_SNAP:  r.read_data = sh_snap;
					fnwc_pkg::RG_CLOCK: r.read_data = sh_clock;
					fnwc_pkg::RG_BT0:   r.read_data = sh_bt[0];
					fnwc_pkg::RG_BT1:   r.read_data = sh_bt[1];
					default:            r.status = fnwc_pkg::ST_INVAL;
				endcase
			end
			fnwc_pkg::FN_SETF: begin
				if (c.frame_value > fnwc_pkg::FRAME_MASK) begin
					r.status = fnwc_pkg::ST_INVAL;
				end else begin
					sh_ref = c.frame_value;
					sh_refv = 1'b1;
					sh_pulse = '0;
					sh_clock = '0;
					sh_snap = '0;
					sh_en = 1'b1;
					sh_ctrl[fnwc_pkg::ENABLE_BIT] = 1'b1;
				end
			end
			fnwc_pkg::FN_GETF: begin
				if (!sh_en || !sh_refv) begin
					r.status = fnwc_pkg::ST_IO;
				end else begin
					frm = 32'(fnwc_pkg::FRAMES_PER_SECOND) * sh_pulse * 32'(sh_period);
					if (sh_rate != 0) begin
						prod = 64'(sh_clock) * 64'(fnwc_pkg::CLOCK_SCALE);
						frm = frm + 32'(prod / 64'(sh_rate));
					end
					frm = frm + 32'(sh_ref);
					r.read_data = frm & 32'(fnwc_pkg::FRAME_MASK);
				end
			end
			fnwc_pkg::FN_SETR: begin
				if (c.frame_value > fnwc_pkg::FRAME_MASK) begin
					r.status = fnwc_pkg::ST_INVAL;
				end else begin
					sh_ref = c.frame_value;
					sh_refv = 1'b1;
				end
			end
			fnwc_pkg::FN_GETR: begin
				if (!sh_refv) r.status = fnwc_pkg::ST_NOREF;
				else r.read_data = 32'(sh_ref);
			end
			default: r.status = fnwc_pkg::ST_INVAL;
		endcase
		return r;
	endfunction

	// driver: push holds while full; prediction happens at the transfer edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				result_q.push_back(predict_command(din));
				sent <= sent + 1;
			end
			if (!(push && full)) begin
				if (cmd_q.size() != 0 && !hold_push &&
				    $urandom_range(99) >= send_idle_pct) begin
					din <= cmd_q.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each popped result with the oldest prediction
	always @(posedge clk) begin
		fnwc_pkg::out_t exp_r;
		if (arst_n) begin
			if (pop && !empty) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, dout);
					failed = 1'b1;
				end else begin
					exp_r = result_q.pop_front();
					if (dout.read_data !== exp_r.read_data) begin
						$display("%0t: read_data expected %h actual %h",
						         $time, exp_r.read_data, dout.read_data);
						failed = 1'b1;
					end
					if (dout.status !== exp_r.status) begin
						$display("%0t: status expected %0d actual %0d",
						         $time, exp_r.status, dout.status);
						failed = 1'b1;
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic fnwc_pkg::in_t make_cmd(fnwc_pkg::func_t f, fnwc_pkg::reg_t r,
	                                           logic [31:0] d, logic [15:0] fv);
		fnwc_pkg::in_t c;
		c.func = f;
		c.reg_index = r;
		c.write_data = d;
		c.frame_value = fv;
		return c;
	endfunction

	// clock values, half of them near the small limits used in the random phases
	function automatic logic [31:0] sh_limit_hint();
		return $urandom_range(1) ? 32'($urandom_range(40)) : $urandom;
	endfunction

	// ticks and frame queries make up half the mix, with clock writes kept near
	// the small limits so pulses and the frame sum actually move
	function automatic fnwc_pkg::in_t random_cmd();
		int k;
		logic [15:0] fv;
		fnwc_pkg::reg_t ri;
		k = $urandom_range(99);
		fv = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1023));
		ri = fnwc_pkg::reg_t'($urandom_range(7));
		if (k < 40) return make_cmd(fnwc_pkg::FN_TICK, ri, $urandom, fv);
		if (k < 50) return make_cmd(fnwc_pkg::FN_GETF, ri, $urandom, fv);
		if (k < 58) return make_cmd(fnwc_pkg::FN_RD, ri, $urandom, fv);
		if (k < 64) return make_cmd(fnwc_pkg::FN_WR, fnwc_pkg::RG_CLOCK, sh_limit_hint(), fv);
		if (k < 72) return make_cmd(fnwc_pkg::FN_WR, ri,
		                            ($urandom_range(1) ? $urandom : $urandom_range(3)), fv);
		if (k < 80) return make_cmd(fnwc_pkg::FN_SETF, ri, $urandom, fv);
		if (k < 86) return make_cmd(fnwc_pkg::FN_SETR, ri, $urandom, fv);
		if (k < 92) return make_cmd(fnwc_pkg::FN_GETR, ri, $urandom, fv);
		if (k < 96) return make_cmd(fnwc_pkg::FN_WR, fnwc_pkg::RG_CTRL, $urandom, fv);
		return make_cmd(fnwc_pkg::func_t'($urandom_range(7)), ri,
		                $urandom, 16'($urandom));
	endfunction

	task automatic write_cfg(logic idx, logic [29:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == fnwc_pkg::CFG_PERIOD) sh_period = v[7:0];
		else sh_rate = v;
	endtask

	// wait until every pushed command has its result, then let the back part settle
	task automatic drain();
		while (cmd_q.size() != 0 || push || result_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) cmd_q.push_back(random_cmd());
		drain();
	endtask

	initial begin
		shadow_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: error paths before any reference, then every function
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_GETR, fnwc_pkg::RG_CTRL, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_GETF, fnwc_pkg::RG_CTRL, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_TICK, fnwc_pkg::RG_CTRL, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_WR, fnwc_pkg::RG_SNAP, 32'hFFFFFFFF, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_WR, fnwc_pkg::RG_BAD6, 32'h1, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_RD, fnwc_pkg::RG_BAD7, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_BAD, fnwc_pkg::RG_BAD7, 32'hFFFFFFFF,
		                         16'hFFFF));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_SETF, fnwc_pkg::RG_CTRL, '0, 16'd1024));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_SETR, fnwc_pkg::RG_CTRL, '0, 16'hFFFF));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_SETR, fnwc_pkg::RG_CTRL, '0, 16'd1023));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_GETR, fnwc_pkg::RG_CTRL, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_WR, fnwc_pkg::RG_BT0, 32'hFFFFFFFF, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_WR, fnwc_pkg::RG_BT1, 32'hA5A5A5A5, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_RD, fnwc_pkg::RG_BT0, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_RD, fnwc_pkg::RG_BT1, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_SETF, fnwc_pkg::RG_CTRL, '0, 16'd1023));
		// clock at the top of the range wraps on the next tick
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_WR, fnwc_pkg::RG_CLOCK, 32'hFFFFFFFF, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_TICK, fnwc_pkg::RG_CTRL, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_WR, fnwc_pkg::RG_PULSE, 32'hFFFFFFFF, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_GETF, fnwc_pkg::RG_CTRL, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_RD, fnwc_pkg::RG_SNAP, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_RD, fnwc_pkg::RG_PULSE, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_WR, fnwc_pkg::RG_CTRL, 32'hFFFFFFFE, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_GETF, fnwc_pkg::RG_CTRL, '0, '0));
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_RD, fnwc_pkg::RG_CTRL, '0, '0));
		drain();

		// phase 1: sender idles 30, receiver 62, small limit so wraps happen
		send_idle_pct = 30;
		recv_idle_pct = 62;
		write_cfg(fnwc_pkg::CFG_PERIOD, 30'd3);
		write_cfg(fnwc_pkg::CFG_RATE, 30'd7);
		run_random(100);
		// hold pushing with a frame query waiting in the driver queue, then resume
		hold_push = 1'b1;
		cmd_q.push_back(make_cmd(fnwc_pkg::FN_GETF, fnwc_pkg::RG_CTRL, '0, '0));
		repeat (20) @(posedge clk);
		hold_push = 1'b0;
		run_random(100);

		// phase 2: swapped idling, extremes of the registers
		send_idle_pct = 62;
		recv_idle_pct = 30;
		write_cfg(fnwc_pkg::CFG_PERIOD, 30'd255);
		write_cfg(fnwc_pkg::CFG_RATE, 30'd1000000000);
		run_random(100);
		write_cfg(fnwc_pkg::CFG_PERIOD, 30'd0);
		write_cfg(fnwc_pkg::CFG_RATE, 30'd0);
		run_random(50);

		// phase 3: no idling, other extremes
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_cfg(fnwc_pkg::CFG_PERIOD, 30'd1);
		write_cfg(fnwc_pkg::CFG_RATE, 30'd1);
		run_random(100);
		write_cfg(fnwc_pkg::CFG_PERIOD, 30'd255);
		write_cfg(fnwc_pkg::CFG_RATE, 30'h3FFFFFFF);
		run_random(50);
		write_cfg(fnwc_pkg::CFG_PERIOD, 30'd2);
		write_cfg(fnwc_pkg::CFG_RATE, 30'd13);
		run_random(100);

		if (!failed) begin
			$display("frame_number_wall_clock_core test passed");
		end else begin
			$display("frame_number_wall_clock_core test failed");
		end
		$finish;
	end

	// watchdog well above the slowest correct run
	initial begin
		#4000000;
		$display("frame_number_wall_clock_core test failed");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/fnwc_pkg.sv
hw/rtl/fnwc_front.sv
hw/rtl/fnwc_div.sv
hw/rtl/fnwc_back.sv
hw/rtl/frame_number_wall_clock_core.sv
bench/tb.sv
